FILE: rtl/core/tfp_pkg.sv
// ----------------------------------------------------------------------------
// tfp_pkg
// Widths, stage indexes and shared types of the Fermat point pipeline.
// ----------------------------------------------------------------------------
package tfp_pkg;

  localparam int COORD_W   = 32;
  localparam int WORK_BITS = 20;
  localparam int T_BITS    = 20;
  localparam int SH_W      = 4;

  localparam int DIFF_W  = COORD_W + 1;
  localparam int OFS_W   = WORK_BITS + 1;
  localparam int EDGE_W  = OFS_W + 1;
  localparam int SQ_W    = 2 * EDGE_W;
  localparam int DOT_W   = SQ_W + 1;
  localparam int HALF_W  = SQ_W / 2;
  localparam int PP_W    = 2 * HALF_W;
  localparam int CMP_W   = 2 * SQ_W + 2;
  localparam int ROT_SH  = 30;
  localparam int ROT_W   = 56;
  localparam int D_W     = 26;
  localparam int ND_W    = 54;
  localparam int QUO_W   = T_BITS + 1;
  localparam int DIVD_W  = ND_W + QUO_W;
  localparam int OFFP_W  = 48;

  localparam int STG_DIV0 = 10;
  localparam int STG_MUL  = STG_DIV0 + QUO_W;
  localparam int NUM_STG  = STG_MUL + 2;

  // sqrt(3)/2 in Q1.30
  localparam logic signed [30:0] HALF_ROOT3 = 31'sd929887697;

  localparam logic [1:0] KIND_INTERIOR = 2'd0;

  typedef enum logic [1:0] {
    TSEL_ZERO,
    TSEL_ONE,
    TSEL_DIV
  } tsel_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic       fixed;
    coord_t     fx;
    coord_t     fy;
    logic [1:0] kind;
    logic       err;
  } res_t;

  typedef struct packed {
    coord_t                  ax;
    coord_t                  ay;
    logic signed [OFS_W-1:0] oax;
    logic signed [OFS_W-1:0] oay;
    logic [SH_W-1:0]         sh;
    logic signed [D_W-1:0]   dx;
    logic signed [D_W-1:0]   dy;
    tsel_t                   tsel;
  } ip_t;

  typedef struct packed {
    res_t res;
    ip_t  ip;
  } side_t;

endpackage

FILE: rtl/core/tfp_div_step.sv
// ----------------------------------------------------------------------------
// tfp_div_step
// One restoring division step: one quotient bit per register stage.
// ----------------------------------------------------------------------------
module tfp_div_step
  import tfp_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [ND_W-1:0]   rem_i,
  input  logic [QUO_W-1:0]  low_i,
  input  logic [QUO_W-1:0]  quo_i,
  input  logic [ND_W-1:0]   den_i,
  input  side_t             side_i,
  output logic [ND_W-1:0]   rem_r,
  output logic [QUO_W-1:0]  low_r,
  output logic [QUO_W-1:0]  quo_r,
  output logic [ND_W-1:0]   den_r,
  output side_t             side_r
);

  logic [ND_W:0]    cat;
  logic [ND_W:0]    dif;
  logic             ge;
  logic [ND_W-1:0]  rem_nxt;

  always_comb begin
    cat     = {rem_i, low_i[QUO_W-1]};
    dif     = cat - {1'b0, den_i};
    ge      = cat >= {1'b0, den_i};
    rem_nxt = ge ? dif[ND_W-1:0] : cat[ND_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      low_r  <= {low_i[QUO_W-2:0], 1'b0};
      quo_r  <= {quo_i[QUO_W-2:0], ge};
      den_r  <= den_i;
      side_r <= side_i;
    end
  end

endmodule

FILE: rtl/core/triangle_fermat_point.sv
// ----------------------------------------------------------------------------
// triangle_fermat_point
// Fermat point of a triangle given as three signed Q16.16 vertices.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_ready with the three vertices; a transfer
//   happens on a rising edge with both high
//   result channel: out_valid / out_ready with the point, its kind (0 for an
//   interior point, 1 to 3 for the obtuse vertex returned) and an error flag
//   (coincident vertices or zero divisor; point then reads as 0,0)
//   pipeline: 33 register stages from the input transfer to out_valid; most
//   of them form the 21 stage bit-serial divider for the line parameter, one
//   quotient bit per stage
//   throughput: one triangle per cycle while out_ready keeps the last stage moving;
//   every stage, the divider included, is fully pipelined and no state is kept between items
//   every stage has its own valid bit and takes new data when it is empty or
//   its successor moves on, so bubbles close up under a stall
//   receiver stall: the last stage holds the result; earlier stages keep
//   filling, and in_ready falls only when every stage is occupied
//   reset: rst_n (synchronous, active low) empties every stage
// ----------------------------------------------------------------------------
module triangle_fermat_point
  import tfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_first_x,
  input  logic signed [31:0] in_first_y,
  input  logic signed [31:0] in_second_x,
  input  logic signed [31:0] in_second_y,
  input  logic signed [31:0] in_third_x,
  input  logic signed [31:0] in_third_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic [1:0]         out_point_kind,
  output logic               out_error_flag
);

  typedef struct packed {
    coord_t [2:0] x;
    coord_t [2:0] y;
  } tri_t;

  localparam logic signed [ROT_W-1:0]  ROT_RND = ROT_W'(1) <<< (ROT_SH - 1);
  localparam logic signed [OFFP_W-1:0] OFF_RND = OFFP_W'(1) <<< (T_BITS - 1);
  localparam logic signed [OFFP_W-1:0] SAT_HI  =
    {{(OFFP_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [OFFP_W-1:0] SAT_LO  =
    {{(OFFP_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  function automatic logic [DIFF_W-1:0] mag_f(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] n;
    n     = -v;
    mag_f = v[DIFF_W-1] ? n : v;
  endfunction

  // ---------------------------------------------------------------- flow control
  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] en;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[NUM_STG-1] = !vld_r[NUM_STG-1] || out_ready;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NUM_STG; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NUM_STG-1];

  // ---------------------------------------------------------------- shared carries
  tri_t            tri_r   [0:5];
  logic [SH_W-1:0] sh_r    [1:5];
  logic            coinc_r [2:5];

  // ---------------------------------------------------------------- stage 0: edges
  logic signed [DIFF_W-1:0] edx_r [3];
  logic signed [DIFF_W-1:0] edy_r [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tri_r[0].x <= {in_third_x, in_second_x, in_first_x};
      tri_r[0].y <= {in_third_y, in_second_y, in_first_y};
      edx_r[0]   <= DIFF_W'(in_second_x) - DIFF_W'(in_first_x);
      edy_r[0]   <= DIFF_W'(in_second_y) - DIFF_W'(in_first_y);
      edx_r[1]   <= DIFF_W'(in_third_x) - DIFF_W'(in_first_x);
      edy_r[1]   <= DIFF_W'(in_third_y) - DIFF_W'(in_first_y);
      edx_r[2]   <= DIFF_W'(in_third_x) - DIFF_W'(in_second_x);
      edy_r[2]   <= DIFF_W'(in_third_y) - DIFF_W'(in_second_y);
    end
  end

  // ---------------------------------------------------------------- stage 1: shift
  // the top set bit of the or of all edge magnitudes sets the working shift
  logic [DIFF_W-1:0]        mag_or;
  logic [SH_W-1:0]          sh_nxt;
  logic signed [DIFF_W-1:0] e1x_r [2];
  logic signed [DIFF_W-1:0] e1y_r [2];

  always_comb begin
    mag_or = '0;
    for (int k = 0; k < 3; k++) begin
      mag_or = mag_or | mag_f(edx_r[k]) | mag_f(edy_r[k]);
    end
    sh_nxt = '0;
    for (int b = WORK_BITS; b < DIFF_W; b++) begin
      if (mag_or[b]) sh_nxt = SH_W'(b - WORK_BITS + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sh_r[1]  <= sh_nxt;
      tri_r[1] <= tri_r[0];
      e1x_r[0] <= edx_r[0];
      e1y_r[0] <= edy_r[0];
      e1x_r[1] <= edx_r[1];
      e1y_r[1] <= edy_r[1];
    end
  end

  // ---------------------------------------------------------------- stage 2: offsets
  logic signed [DIFF_W-1:0] shx [2];
  logic signed [DIFF_W-1:0] shy [2];
  logic signed [OFS_W-1:0]  o2x_r [2];
  logic signed [OFS_W-1:0]  o2y_r [2];
  logic                     coinc_nxt;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      shx[k] = e1x_r[k] >>> sh_r[1];
      shy[k] = e1y_r[k] >>> sh_r[1];
    end
    coinc_nxt = (shx[0][OFS_W-1:0] == '0 && shy[0][OFS_W-1:0] == '0) ||
                (shx[1][OFS_W-1:0] == '0 && shy[1][OFS_W-1:0] == '0) ||
                (shx[0][OFS_W-1:0] == shx[1][OFS_W-1:0] &&
                 shy[0][OFS_W-1:0] == shy[1][OFS_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 2; k++) begin
        o2x_r[k] <= shx[k][OFS_W-1:0];
        o2y_r[k] <= shy[k][OFS_W-1:0];
      end
      coinc_r[2] <= coinc_nxt;
      sh_r[2]    <= sh_r[1];
      tri_r[2]   <= tri_r[1];
    end
  end

  // ---------------------------------------------------------------- stage 3: dots
  logic signed [OFS_W-1:0]  ofx [3];
  logic signed [OFS_W-1:0]  ofy [3];
  logic signed [EDGE_W-1:0] ux [3];
  logic signed [EDGE_W-1:0] uy [3];
  logic signed [EDGE_W-1:0] wx [3];
  logic signed [EDGE_W-1:0] wy [3];
  logic signed [DOT_W-1:0]  dot [3];
  logic signed [SQ_W-1:0]   nu [3];
  logic signed [SQ_W-1:0]   nw [3];

  logic signed [EDGE_W-1:0] u3x_r [3];
  logic signed [EDGE_W-1:0] u3y_r [3];
  logic signed [EDGE_W-1:0] w3x_r [3];
  logic signed [EDGE_W-1:0] w3y_r [3];
  logic signed [DOT_W-1:0]  dot3_r [3];
  logic [SQ_W-1:0]          nu3_r [3];
  logic [SQ_W-1:0]          nw3_r [3];
  logic signed [OFS_W-1:0]  o3x_r [2];
  logic signed [OFS_W-1:0]  o3y_r [2];

  always_comb begin
    ofx[0] = '0;
    ofy[0] = '0;
    ofx[1] = o2x_r[0];
    ofy[1] = o2y_r[0];
    ofx[2] = o2x_r[1];
    ofy[2] = o2y_r[1];
    for (int k = 0; k < 3; k++) begin
      ux[k]  = EDGE_W'(ofx[(k+1)%3]) - EDGE_W'(ofx[k]);
      uy[k]  = EDGE_W'(ofy[(k+1)%3]) - EDGE_W'(ofy[k]);
      wx[k]  = EDGE_W'(ofx[(k+2)%3]) - EDGE_W'(ofx[k]);
      wy[k]  = EDGE_W'(ofy[(k+2)%3]) - EDGE_W'(ofy[k]);
      dot[k] = DOT_W'(ux[k]) * DOT_W'(wx[k]) + DOT_W'(uy[k]) * DOT_W'(wy[k]);
      nu[k]  = SQ_W'(ux[k]) * SQ_W'(ux[k]) + SQ_W'(uy[k]) * SQ_W'(uy[k]);
      nw[k]  = SQ_W'(wx[k]) * SQ_W'(wx[k]) + SQ_W'(wy[k]) * SQ_W'(wy[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 3; k++) begin
        u3x_r[k]  <= ux[k];
        u3y_r[k]  <= uy[k];
        w3x_r[k]  <= wx[k];
        w3y_r[k]  <= wy[k];
        dot3_r[k] <= dot[k];
        nu3_r[k]  <= nu[k];
        nw3_r[k]  <= nw[k];
      end
      o3x_r      <= o2x_r;
      o3y_r      <= o2y_r;
      coinc_r[3] <= coinc_r[2];
      sh_r[3]    <= sh_r[2];
      tri_r[3]   <= tri_r[2];
    end
  end

  // ---------------------------------------------------------------- stage 4
  // obtuse test partial products; pick the largest angle (longest opposite side)
  logic [SQ_W-1:0]          adot [3];
  logic [SQ_W-1:0]          len [3];
  logic [1:0]               ai;
  logic signed [OFS_W-1:0]  oax_nxt;
  logic signed [OFS_W-1:0]  oay_nxt;

  logic [PP_W-1:0]          ahh_r [3];
  logic [PP_W-1:0]          ahl_r [3];
  logic [PP_W-1:0]          all_r [3];
  logic [PP_W-1:0]          nhh_r [3];
  logic [PP_W-1:0]          nhl_r [3];
  logic [PP_W-1:0]          nlh_r [3];
  logic [PP_W-1:0]          nll_r [3];
  logic                     neg4_r [3];
  logic signed [EDGE_W-1:0] q4x_r, q4y_r, r4x_r, r4y_r;
  logic signed [OFS_W-1:0]  oa4x_r, oa4y_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      adot[k] = dot3_r[k][DOT_W-1] ? SQ_W'(-dot3_r[k]) : SQ_W'(dot3_r[k]);
      len[k]  = nu3_r[(k+1)%3];
    end
    ai = (len[0] > len[1]) ? 2'd0 : 2'd1;
    if (!(len[ai] > len[2])) ai = 2'd2;
    case (ai)
      2'd1: begin
        oax_nxt = o3x_r[0];
        oay_nxt = o3y_r[0];
      end
      2'd2: begin
        oax_nxt = o3x_r[1];
        oay_nxt = o3y_r[1];
      end
      default: begin
        oax_nxt = '0;
        oay_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < 3; k++) begin
        ahh_r[k]  <= PP_W'(adot[k][SQ_W-1:HALF_W]) * PP_W'(adot[k][SQ_W-1:HALF_W]);
        ahl_r[k]  <= PP_W'(adot[k][SQ_W-1:HALF_W]) * PP_W'(adot[k][HALF_W-1:0]);
        all_r[k]  <= PP_W'(adot[k][HALF_W-1:0]) * PP_W'(adot[k][HALF_W-1:0]);
        nhh_r[k]  <= PP_W'(nu3_r[k][SQ_W-1:HALF_W]) * PP_W'(nw3_r[k][SQ_W-1:HALF_W]);
        nhl_r[k]  <= PP_W'(nu3_r[k][SQ_W-1:HALF_W]) * PP_W'(nw3_r[k][HALF_W-1:0]);
        nlh_r[k]  <= PP_W'(nu3_r[k][HALF_W-1:0]) * PP_W'(nw3_r[k][SQ_W-1:HALF_W]);
        nll_r[k]  <= PP_W'(nu3_r[k][HALF_W-1:0]) * PP_W'(nw3_r[k][HALF_W-1:0]);
        neg4_r[k] <= dot3_r[k][DOT_W-1];
      end
      q4x_r      <= u3x_r[ai];
      q4y_r      <= u3y_r[ai];
      r4x_r      <= w3x_r[ai];
      r4y_r      <= w3y_r[ai];
      oa4x_r     <= oax_nxt;
      oa4y_r     <= oay_nxt;
      coinc_r[4] <= coinc_r[3];
      sh_r[4]    <= sh_r[3];
      tri_r[4]   <= tri_r[3];
    end
  end

  // ---------------------------------------------------------------- stage 5
  // obtuse sums; orientation and products with sqrt(3)/2
  logic signed [DOT_W-1:0]  cr;
  logic signed [EDGE_W:0]   t1, t2;

  logic [CMP_W-1:0]         lhs5_r [3];
  logic [CMP_W-1:0]         rhs5_r [3];
  logic                     neg5_r [3];
  logic                     crpos5_r;
  logic signed [ROT_W-1:0]  p1_r, p2_r, p3_r, p4_r;
  logic signed [EDGE_W:0]   sx5_r, sy5_r;
  logic signed [EDGE_W-1:0] q5x_r, q5y_r, r5x_r, r5y_r;
  logic signed [OFS_W-1:0]  oa5x_r, oa5y_r;

  always_comb begin
    cr = DOT_W'(q4x_r) * DOT_W'(r4y_r) - DOT_W'(q4y_r) * DOT_W'(r4x_r);
    t1 = (EDGE_W+1)'(r4y_r) - (EDGE_W+1)'(q4y_r);
    t2 = (EDGE_W+1)'(r4x_r) - (EDGE_W+1)'(q4x_r);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int k = 0; k < 3; k++) begin
        lhs5_r[k] <= ((CMP_W'(ahh_r[k]) << (2 * HALF_W)) +
                      (CMP_W'(ahl_r[k]) << (HALF_W + 1)) + CMP_W'(all_r[k])) << 2;
        rhs5_r[k] <= (CMP_W'(nhh_r[k]) << (2 * HALF_W)) +
                     ((CMP_W'(nhl_r[k]) + CMP_W'(nlh_r[k])) << HALF_W) +
                     CMP_W'(nll_r[k]);
        neg5_r[k] <= neg4_r[k];
      end
      crpos5_r   <= cr > 0;
      p1_r       <= ROT_W'(HALF_ROOT3) * ROT_W'(t1);
      p2_r       <= ROT_W'(HALF_ROOT3) * ROT_W'(t2);
      p3_r       <= ROT_W'(HALF_ROOT3) * ROT_W'(r4y_r);
      p4_r       <= ROT_W'(HALF_ROOT3) * ROT_W'(r4x_r);
      sx5_r      <= (EDGE_W+1)'(q4x_r) + (EDGE_W+1)'(r4x_r);
      sy5_r      <= (EDGE_W+1)'(q4y_r) + (EDGE_W+1)'(r4y_r);
      q5x_r      <= q4x_r;
      q5y_r      <= q4y_r;
      r5x_r      <= r4x_r;
      r5y_r      <= r4y_r;
      oa5x_r     <= oa4x_r;
      oa5y_r     <= oa4y_r;
      coinc_r[5] <= coinc_r[4];
      sh_r[5]    <= sh_r[4];
      tri_r[5]   <= tri_r[4];
    end
  end

  // ---------------------------------------------------------------- stage 6
  // obtuse decision; outer apex d and second vertex rotated e, g = e - q
  res_t                    res6;
  ip_t                     ip6;
  logic signed [ROT_W-1:0] acc_dx, acc_dy, acc_ex, acc_ey;
  logic signed [ROT_W-1:0] rot_dx, rot_dy, rot_ex, rot_ey;
  logic signed [D_W-1:0]   ex6, ey6;

  side_t                   side6_r;
  logic signed [D_W-1:0]   g6x_r, g6y_r;
  logic signed [EDGE_W-1:0] q6x_r, q6y_r;

  always_comb begin
    res6      = '0;
    res6.kind = KIND_INTERIOR;
    for (int k = 2; k >= 0; k--) begin
      if (neg5_r[k] && lhs5_r[k] > rhs5_r[k]) begin
        res6.fixed = 1'b1;
        res6.fx    = tri_r[5].x[k];
        res6.fy    = tri_r[5].y[k];
        res6.kind  = 2'(k + 1);
      end
    end
    if (coinc_r[5]) begin
      res6.fixed = 1'b1;
      res6.fx    = '0;
      res6.fy    = '0;
      res6.kind  = KIND_INTERIOR;
      res6.err   = 1'b1;
    end

    acc_dx = (ROT_W'(sx5_r) <<< (ROT_SH - 1)) + (crpos5_r ? p1_r : -p1_r) + ROT_RND;
    acc_dy = (ROT_W'(sy5_r) <<< (ROT_SH - 1)) - (crpos5_r ? p2_r : -p2_r) + ROT_RND;
    acc_ex = (ROT_W'(r5x_r) <<< (ROT_SH - 1)) - (crpos5_r ? p3_r : -p3_r) + ROT_RND;
    acc_ey = (ROT_W'(r5y_r) <<< (ROT_SH - 1)) + (crpos5_r ? p4_r : -p4_r) + ROT_RND;
    rot_dx = acc_dx >>> ROT_SH;
    rot_dy = acc_dy >>> ROT_SH;
    rot_ex = acc_ex >>> ROT_SH;
    rot_ey = acc_ey >>> ROT_SH;
    ex6    = rot_ex[D_W-1:0];
    ey6    = rot_ey[D_W-1:0];

    ip6      = '0;
    ip6.ax   = tri_r[5].x[0];
    ip6.ay   = tri_r[5].y[0];
    ip6.oax  = oa5x_r;
    ip6.oay  = oa5y_r;
    ip6.sh   = sh_r[5];
    ip6.dx   = rot_dx[D_W-1:0];
    ip6.dy   = rot_dy[D_W-1:0];
    ip6.tsel = TSEL_ZERO;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      side6_r.res <= res6;
      side6_r.ip  <= ip6;
      g6x_r       <= ex6 - D_W'(q5x_r);
      g6y_r       <= ey6 - D_W'(q5y_r);
      q6x_r       <= q5x_r;
      q6y_r       <= q5y_r;
    end
  end

  // ---------------------------------------------------------------- stage 7: cross products
  logic signed [ND_W-1:0] num7_r, den7_r;
  side_t                  side7_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      num7_r  <= ND_W'(q6x_r) * ND_W'(g6y_r) - ND_W'(q6y_r) * ND_W'(g6x_r);
      den7_r  <= ND_W'(side6_r.ip.dx) * ND_W'(g6y_r) -
                 ND_W'(side6_r.ip.dy) * ND_W'(g6x_r);
      side7_r <= side6_r;
    end
  end

  // ---------------------------------------------------------------- stage 8: sign fix
  side_t                  side8_nxt;
  logic signed [ND_W-1:0] num8_r;
  logic [ND_W-1:0]        den8_r;
  side_t                  side8_r;

  always_comb begin
    side8_nxt = side7_r;
    if (den7_r == '0 && !side7_r.res.fixed) begin
      side8_nxt.res.fixed = 1'b1;
      side8_nxt.res.fx    = '0;
      side8_nxt.res.fy    = '0;
      side8_nxt.res.kind  = KIND_INTERIOR;
      side8_nxt.res.err   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      num8_r  <= den7_r[ND_W-1] ? -num7_r : num7_r;
      den8_r  <= den7_r[ND_W-1] ? -den7_r : den7_r;
      side8_r <= side8_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 9: clamp, dividend
  logic [DIVD_W-1:0] dvd;
  side_t             side9_nxt;

  logic [ND_W-1:0]   rem_c  [0:QUO_W];
  logic [QUO_W-1:0]  low_c  [0:QUO_W];
  logic [QUO_W-1:0]  quo_c  [0:QUO_W];
  logic [ND_W-1:0]   den_c  [0:QUO_W];
  side_t             side_c [0:QUO_W];

  always_comb begin
    side9_nxt = side8_r;
    if (num8_r <= 0) begin
      side9_nxt.ip.tsel = TSEL_ZERO;
    end else if ($unsigned(num8_r) >= den8_r) begin
      side9_nxt.ip.tsel = TSEL_ONE;
    end else begin
      side9_nxt.ip.tsel = TSEL_DIV;
    end
    dvd = ({{(DIVD_W-ND_W){1'b0}}, num8_r} << T_BITS) +
          {{(DIVD_W-ND_W+1){1'b0}}, den8_r[ND_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (en[STG_DIV0-1]) begin
      rem_c[0]  <= dvd[DIVD_W-1:QUO_W];
      low_c[0]  <= dvd[QUO_W-1:0];
      quo_c[0]  <= '0;
      den_c[0]  <= den8_r;
      side_c[0] <= side9_nxt;
    end
  end

  // ---------------------------------------------------------------- divider stages
  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    tfp_div_step u_step (
      .clk    (clk),
      .en     (en[STG_DIV0+i]),
      .rem_i  (rem_c[i]),
      .low_i  (low_c[i]),
      .quo_i  (quo_c[i]),
      .den_i  (den_c[i]),
      .side_i (side_c[i]),
      .rem_r  (rem_c[i+1]),
      .low_r  (low_c[i+1]),
      .quo_r  (quo_c[i+1]),
      .den_r  (den_c[i+1]),
      .side_r (side_c[i+1])
    );
  end

  // ---------------------------------------------------------------- line parameter times d
  logic [QUO_W-1:0]        tpar;
  logic signed [OFFP_W-1:0] px_r, py_r;
  side_t                   side_m_r;

  always_comb begin
    case (side_c[QUO_W].ip.tsel)
      TSEL_ONE: tpar = QUO_W'(1) << T_BITS;
      TSEL_DIV: tpar = quo_c[QUO_W];
      default:  tpar = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[STG_MUL]) begin
      px_r     <= OFFP_W'(side_c[QUO_W].ip.dx) * OFFP_W'($signed({1'b0, tpar}));
      py_r     <= OFFP_W'(side_c[QUO_W].ip.dy) * OFFP_W'($signed({1'b0, tpar}));
      side_m_r <= side_c[QUO_W];
    end
  end

  // ---------------------------------------------------------------- output stage
  logic signed [OFFP_W-1:0] offx, offy, sumx, sumy, totx, toty;
  logic signed [COORD_W-1:0] ptx, pty;

  logic signed [COORD_W-1:0] out_x_r, out_y_r;
  logic [1:0]                out_kind_r;
  logic                      out_err_r;

  always_comb begin
    offx = (px_r + OFF_RND) >>> T_BITS;
    offy = (py_r + OFF_RND) >>> T_BITS;
    sumx = (offx + OFFP_W'(side_m_r.ip.oax)) <<< side_m_r.ip.sh;
    sumy = (offy + OFFP_W'(side_m_r.ip.oay)) <<< side_m_r.ip.sh;
    totx = sumx + OFFP_W'(side_m_r.ip.ax);
    toty = sumy + OFFP_W'(side_m_r.ip.ay);
    // saturate into the coordinate range
    if (totx > SAT_HI) ptx = SAT_HI[COORD_W-1:0];
    else if (totx < SAT_LO) ptx = SAT_LO[COORD_W-1:0];
    else ptx = totx[COORD_W-1:0];
    if (toty > SAT_HI) pty = SAT_HI[COORD_W-1:0];
    else if (toty < SAT_LO) pty = SAT_LO[COORD_W-1:0];
    else pty = toty[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STG-1]) begin
      if (side_m_r.res.fixed) begin
        out_x_r    <= side_m_r.res.fx;
        out_y_r    <= side_m_r.res.fy;
        out_kind_r <= side_m_r.res.kind;
        out_err_r  <= side_m_r.res.err;
      end else begin
        out_x_r    <= ptx;
        out_y_r    <= pty;
        out_kind_r <= KIND_INTERIOR;
        out_err_r  <= 1'b0;
      end
    end
  end

  assign out_point_x    = out_x_r;
  assign out_point_y    = out_y_r;
  assign out_point_kind = out_kind_r;
  assign out_error_flag = out_err_r;

  // ---------------------------------------------------------------- assertions
  a_err_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_flag |->
      out_point_x == '0 && out_point_y == '0 && out_point_kind == KIND_INTERIOR)
    else $error("error result carries a nonzero point or kind");

  a_vertex_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_kind != KIND_INTERIOR |-> !out_error_flag)
    else $error("vertex result flagged as error");

  a_div_operands: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[STG_DIV0-1] && side_c[0].ip.tsel == TSEL_DIV |->
      den_c[0] != '0 && rem_c[0] < den_c[0])
    else $error("divider entered with bad operands");

endmodule
